@@ design/write_hotness_label_tracker_defines.svh @@
// Assertion macros shared by the checker files of the write hotness label tracker.
`ifndef WRITE_HOTNESS_LABEL_TRACKER_DEFINES_SVH
`define WRITE_HOTNESS_LABEL_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define WHLT_ASSERT_IMPLY(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("write hotness label tracker: check failed");

// Next-cycle implication, disabled while reset is active.
`define WHLT_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("write hotness label tracker: check failed");

`endif

@@ design/whlt_pkg.sv @@
// Shared types, constants and helper functions of the write hotness label tracker.
package whlt_pkg;

    // Sizes
    localparam int MAX_GROUPS      = 4096;
    localparam int GRP_W           = 12;
    localparam int GCOUNT_W        = 13;
    localparam int PG_SHIFT        = 6;
    localparam int PAGES_PER_GROUP = 64;
    localparam int MAPPED_W        = 7;
    localparam int RING_DEPTH      = 64;
    localparam int RING_W          = 6;
    localparam int LOG_BINS        = 40;
    localparam int FREQ_BINS       = 17;
    localparam int DENS_BINS       = 11;
    localparam int BURST_MAX       = 64;
    localparam int Q_DEPTH         = 2;
    localparam int CFG_W           = 40;
    localparam int CFG_IDX_W       = 3;
    localparam logic [15:0] FREQ_TOP = 16'hFFFF;

    // Histogram memory layout: one counter memory holds every table.
    localparam int HIST_DEPTH = 512;
    localparam int HIST_AW    = 9;
    localparam int HB_LABEL   = 0;
    localparam int HB_FREQ    = HB_LABEL + 2;
    localparam int HB_AGE     = HB_FREQ + 2 * FREQ_BINS;
    localparam int HB_GAP     = HB_AGE + 2 * LOG_BINS;
    localparam int HB_DENS    = HB_GAP + 2 * LOG_BINS;
    localparam int HB_PAIR    = HB_DENS + 2 * DENS_BINS;

    // Request modes
    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_SAMPLE  = 2'd1;
    localparam logic [1:0] MODE_RESOLVE = 2'd2;
    localparam logic [1:0] MODE_READ    = 2'd3;

    // Counter kinds
    localparam logic [2:0] HK_LABEL   = 3'd0;
    localparam logic [2:0] HK_FREQ    = 3'd1;
    localparam logic [2:0] HK_AGE     = 3'd2;
    localparam logic [2:0] HK_GAP     = 3'd3;
    localparam logic [2:0] HK_DENS    = 3'd4;
    localparam logic [2:0] HK_PAIR    = 3'd5;
    localparam logic [2:0] HK_DROPPED = 3'd6;
    localparam logic [2:0] HK_PENDING = 3'd7;

    // Result kinds
    localparam logic [1:0] RK_DONE     = 2'd0;
    localparam logic [1:0] RK_DROP     = 2'd1;
    localparam logic [1:0] RK_RESOLVED = 2'd2;
    localparam logic [1:0] RK_COUNTER  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_GROUP_COUNT = 3'd0;
    localparam logic [2:0] CFG_HORIZON     = 3'd1;
    localparam logic [2:0] CFG_PERIOD      = 3'd2;
    localparam logic [2:0] CFG_COARSE_BASE = 3'd3;
    localparam logic [2:0] CFG_COARSE_STEP = 3'd4;

    typedef struct packed {
        logic [12:0] group_count;
        logic [39:0] horizon;
        logic [39:0] period;
        logic [5:0]  coarse_base;
        logic [5:0]  coarse_step;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic        in_range;
        logic [11:0] grp;
        logic [63:0] now;
        logic        ow;
        logic [2:0]  hk;
        logic [5:0]  hidx;
        logic        hlab;
    } cmd_t;

    typedef struct packed {
        logic [15:0] freq;
        logic [6:0]  mapped;
        logic [63:0] gap_avg;
        logic [63:0] last_inval;
        logic [31:0] seq;
    } grp_t;

    typedef struct packed {
        logic [63:0] t0;
        logic [11:0] grp;
        logic [31:0] seq0;
        logic [4:0]  fb;
        logic [5:0]  ab;
        logic [5:0]  gb;
        logic [3:0]  db;
    } ring_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        label;
        logic [4:0]  fb;
        logic [5:0]  ab;
        logic [5:0]  gb;
        logic [3:0]  db;
        logic [2:0]  gc;
        logic [2:0]  ac;
        logic [11:0] grp;
        logic [63:0] value;
        logic        last;
    } res_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_SW_RD, ST_SW_WB, ST_GRD, ST_G1,
        ST_WR_WB, ST_SMP_WB, ST_EMIT, ST_HRD, ST_H1, ST_RS_CHK, ST_RS_RD,
        ST_RS_FLUSH, ST_RS_SEQ, ST_RS_LBL, ST_RS_DIV, ST_RS_HRD, ST_RS_HWB,
        ST_RS_DONE, ST_RS_FIN
    } bk_state_t;

    // Number of groups in use, capped at the table depth.
    function automatic logic [12:0] live_groups(input logic [12:0] gc);
        return (gc > 13'(MAX_GROUPS)) ? 13'(MAX_GROUPS) : gc;
    endfunction

    // Bit length of a frequency value.
    function automatic logic [4:0] bit_len16(input logic [15:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) n = 5'(i + 1);
        end
        return n;
    endfunction

    // Floor log2 bucket, all ones goes to the top bin.
    function automatic logic [5:0] log_bin(input logic [63:0] v);
        logic [6:0] b;
        b = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) b = 7'(i);
        end
        if (&v) return 6'(LOG_BINS - 1);
        if (b >= 7'(LOG_BINS)) return 6'(LOG_BINS - 1);
        return b[5:0];
    endfunction

    // Mapped percent divided by ten; the reciprocal is exact for these values.
    function automatic logic [3:0] dens_bin(input logic [6:0] mapped);
        logic [13:0] pct;
        logic [21:0] q;
        pct = (14'(mapped) * 14'd100) >> PG_SHIFT;
        q   = (22'(pct) * 22'd205) >> 11;
        return (q >= 22'(DENS_BINS)) ? 4'(DENS_BINS - 1) : q[3:0];
    endfunction

    // Whether a counter index lies inside its table.
    function automatic logic hist_idx_ok(input logic [2:0] kind, input logic [5:0] idx);
        logic ok;
        case (kind)
            HK_FREQ:        ok = idx < 6'(FREQ_BINS);
            HK_AGE, HK_GAP: ok = idx < 6'(LOG_BINS);
            HK_DENS:        ok = idx < 6'(DENS_BINS);
            default:        ok = 1'b1;
        endcase
        return ok;
    endfunction

    // Address of a counter in the histogram memory.
    function automatic logic [8:0] hist_addr(input logic [2:0] kind, input logic y,
                                             input logic [5:0] idx);
        int a;
        case (kind)
            HK_LABEL: a = HB_LABEL + int'(y);
            HK_FREQ:  a = HB_FREQ + int'(y) * FREQ_BINS + int'(idx);
            HK_AGE:   a = HB_AGE + int'(y) * LOG_BINS + int'(idx);
            HK_GAP:   a = HB_GAP + int'(y) * LOG_BINS + int'(idx);
            HK_DENS:  a = HB_DENS + int'(y) * DENS_BINS + int'(idx);
            default:  a = HB_PAIR + int'(y) * 64 + int'(idx);
        endcase
        return 9'(a);
    endfunction

endpackage

@@ design/whlt_ifs.sv @@
// Valid/ready channel interfaces for requests and results.
interface whlt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] lpn;
    logic [63:0] now_ns;
    logic        overwrite;
    logic [2:0]  hist_kind;
    logic [5:0]  hist_index;
    logic        hist_label;

    modport source (output valid, mode, lpn, now_ns, overwrite, hist_kind, hist_index,
                    hist_label, input ready);
    modport sink (input valid, mode, lpn, now_ns, overwrite, hist_kind, hist_index,
                  hist_label, output ready);
endinterface

interface whlt_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic        label;
    logic [4:0]  freq_bin;
    logic [5:0]  age_bin;
    logic [5:0]  gap_bin;
    logic [3:0]  dens_bin;
    logic [2:0]  gap_coarse;
    logic [2:0]  age_coarse;
    logic [11:0] group_index;
    logic [63:0] counter_value;
    logic        last;

    modport source (output valid, result_kind, label, freq_bin, age_bin, gap_bin, dens_bin,
                    gap_coarse, age_coarse, group_index, counter_value, last, input ready);
    modport sink (input valid, result_kind, label, freq_bin, age_bin, gap_bin, dens_bin,
                  gap_coarse, age_coarse, group_index, counter_value, last, output ready);
endinterface

@@ design/write_hotness_label_tracker.sv @@
// Top level of the write hotness label tracker.
// After reset the block runs a clearing pass over its group and histogram memories and
// takes no request until it ends; configuration writes are taken throughout.
// Requests go through a two-entry queue into a sequencer that works one request at a time
// and reads and writes each memory through one write port and one read port. A write that
// starts a decay period first runs the halving sweep over the live groups in the group
// memory. A resolve spends its time per labeled sample in the coarse-bin subtraction loop
// and, mostly, in six read-modify-write updates of the histogram memory; it emits one result
// per labeled sample, at most 64 per request, with last marking the final one, or a single
// done result when no sample is labeled.
module write_hotness_label_tracker (
    input  logic                           clk,
    input  logic                           rst_n,
    whlt_in_if.sink                        in_ch,
    whlt_res_if.source                     res_ch,
    input  logic                           cfg_we,
    input  logic [whlt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [whlt_pkg::CFG_W-1:0]     cfg_data
);

    whlt_pkg::cfg_t cfg;
    whlt_pkg::cmd_t q_in, q_out;
    logic           q_push, q_pop, q_ready, q_valid, busy;

    // Front end: configuration and classification.
    whlt_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .busy(busy), .q_ready(q_ready), .q_push(q_push), .q_data(q_in), .cfg(cfg)
    );

    // Command queue.
    whlt_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .ready(q_ready),
        .pop(q_pop), .pop_data(q_out), .valid(q_valid)
    );

    // Back end: memories and sequencer.
    whlt_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .q_valid(q_valid), .q_data(q_out),
        .q_pop(q_pop), .busy(busy), .res_ch(res_ch)
    );

endmodule

@@ design/whlt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module whlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/whlt_front.sv @@
// Front end: configuration registers and request classification.
module whlt_front (
    input  logic                              clk,
    input  logic                              rst_n,
    whlt_in_if.sink                           in_ch,
    input  logic                              cfg_we,
    input  logic [whlt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [whlt_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              busy,
    input  logic                              q_ready,
    output logic                              q_push,
    output whlt_pkg::cmd_t                    q_data,
    output whlt_pkg::cfg_t                    cfg
);

    whlt_pkg::cfg_t cfg_reg;
    whlt_pkg::cfg_t cfg_next;
    logic [12:0]    live;

    // Register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                whlt_pkg::CFG_GROUP_COUNT: cfg_next.group_count = cfg_data[12:0];
                whlt_pkg::CFG_HORIZON:     cfg_next.horizon     = cfg_data;
                whlt_pkg::CFG_PERIOD:      cfg_next.period      = cfg_data;
                whlt_pkg::CFG_COARSE_BASE: cfg_next.coarse_base = cfg_data[5:0];
                whlt_pkg::CFG_COARSE_STEP: cfg_next.coarse_step = cfg_data[5:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.group_count <= 13'd4096;
            cfg_reg.horizon     <= 40'd100000000;
            cfg_reg.period      <= 40'd1000000000;
            cfg_reg.coarse_base <= 6'd18;
            cfg_reg.coarse_step <= 6'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    // Transfers pass straight into the queue while it has room and the back end is not clearing.
    assign in_ch.ready = q_ready && !busy;
    assign q_push      = in_ch.valid && in_ch.ready;

    // Classify: group number and range check against the live group count.
    assign live = whlt_pkg::live_groups(cfg_reg.group_count);

    always_comb
    begin
        q_data.mode     = in_ch.mode;
        q_data.in_range = in_ch.lpn[31:whlt_pkg::PG_SHIFT] < 26'(live);
        q_data.grp      = in_ch.lpn[whlt_pkg::PG_SHIFT+11:whlt_pkg::PG_SHIFT];
        q_data.now      = in_ch.now_ns;
        q_data.ow       = in_ch.overwrite;
        q_data.hk       = in_ch.hist_kind;
        q_data.hidx     = in_ch.hist_index;
        q_data.hlab     = in_ch.hist_label;
    end

endmodule

@@ design/whlt_queue.sv @@
// Short command queue between the front end and the back end.
module whlt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  whlt_pkg::cmd_t push_data,
    output logic           ready,
    input  logic           pop,
    output whlt_pkg::cmd_t pop_data,
    output logic           valid
);

    localparam int PW = $clog2(whlt_pkg::Q_DEPTH);
    localparam int CW = $clog2(whlt_pkg::Q_DEPTH + 1);

    whlt_pkg::cmd_t q_mem [whlt_pkg::Q_DEPTH];
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign ready    = count_reg != CW'(whlt_pkg::Q_DEPTH);
    assign valid    = count_reg != '0;
    assign pop_data = q_mem[rptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PW'(whlt_pkg::Q_DEPTH - 1)) ? '0 : PW'(wptr_reg + 1'b1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PW'(whlt_pkg::Q_DEPTH - 1)) ? '0 : PW'(rptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wptr_reg] <= push_data;
        end
    end

endmodule

@@ design/whlt_back.sv @@
// Back end: sequencer over the group, sample ring and histogram memories.
module whlt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  whlt_pkg::cfg_t cfg,
    input  logic           q_valid,
    input  whlt_pkg::cmd_t q_data,
    output logic           q_pop,
    output logic           busy,
    whlt_res_if.source     res_ch
);

    whlt_pkg::bk_state_t state_reg, state_next;

    whlt_pkg::cmd_t cmd_reg, cmd_next;
    whlt_pkg::grp_t g_reg, g_next;
    whlt_pkg::ring_t ent_reg, ent_next;
    whlt_pkg::res_t res_reg, res_next;
    whlt_pkg::res_t out_reg, out_next;
    logic           out_v_reg, out_v_next;
    logic [11:0]    clr_idx_reg, clr_idx_next;
    logic [12:0]    sweep_idx_reg, sweep_idx_next;
    logic [63:0]    ldt_reg, ldt_next;
    logic [63:0]    drop_reg, drop_next;
    logic [63:0]    diff_reg, diff_next;
    logic [5:0]     head_reg, head_next;
    logic [5:0]     tail_reg, tail_next;
    logic [6:0]     nres_reg, nres_next;
    logic           pend_reg, pend_next;
    logic           y_reg, y_next;
    logic [5:0]     rg_reg, rg_next;
    logic [5:0]     ra_reg, ra_next;
    logic [2:0]     cg_reg, cg_next;
    logic [2:0]     ca_reg, ca_next;
    logic [2:0]     hcnt_reg, hcnt_next;

    // Memory ports
    logic                              g_we;
    logic [11:0]                       g_waddr, g_raddr;
    whlt_pkg::grp_t                    g_wdata, g_rdata;
    logic                              r_we;
    whlt_pkg::ring_t                   r_wdata, r_rdata;
    logic                              h_we;
    logic [whlt_pkg::HIST_AW-1:0]      h_waddr, h_raddr, h_addr_rs;
    logic [63:0]                       h_wdata, h_rdata;

    // Shared decisions
    logic        out_free;
    logic [12:0] live;
    logic        due;
    logic        full;
    logic        late;
    logic [5:0]  step_eff;
    logic        stop_g, stop_a, div_done;
    logic        rd_direct;
    logic [5:0]  idx_rs;

    whlt_ram #(.WIDTH($bits(whlt_pkg::grp_t)), .DEPTH(whlt_pkg::MAX_GROUPS)) u_grp_ram (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata)
    );

    whlt_ram #(.WIDTH($bits(whlt_pkg::ring_t)), .DEPTH(whlt_pkg::RING_DEPTH)) u_ring_ram (
        .clk(clk), .we(r_we), .waddr(tail_reg), .wdata(r_wdata),
        .raddr(head_reg), .rdata(r_rdata)
    );

    whlt_ram #(.WIDTH(64), .DEPTH(whlt_pkg::HIST_DEPTH)) u_hist_ram (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    assign out_free = !out_v_reg || res_ch.ready;
    assign live     = whlt_pkg::live_groups(cfg.group_count);
    assign due      = (cmd_reg.now - ldt_reg) >= 64'(cfg.period);
    assign full     = 6'(tail_reg + 6'd1) == head_reg;
    assign late     = (r_rdata.t0 + 64'(cfg.horizon)) > cmd_reg.now;
    assign step_eff = (cfg.coarse_step == '0) ? 6'd1 : cfg.coarse_step;
    assign stop_g   = (rg_reg < step_eff) || (cg_reg == 3'd7);
    assign stop_a   = (ra_reg < step_eff) || (ca_reg == 3'd7);
    assign div_done = stop_g && stop_a;
    assign busy     = state_reg == whlt_pkg::ST_CLEAR;

    // Counter reads that need no histogram access.
    assign rd_direct = (cmd_reg.hk == whlt_pkg::HK_DROPPED) ||
                       (cmd_reg.hk == whlt_pkg::HK_PENDING) ||
                       !whlt_pkg::hist_idx_ok(cmd_reg.hk, cmd_reg.hidx);

    // Bucket index of the table being counted during a resolve.
    always_comb
    begin
        case (hcnt_reg)
            whlt_pkg::HK_LABEL: idx_rs = '0;
            whlt_pkg::HK_FREQ:  idx_rs = 6'(ent_reg.fb);
            whlt_pkg::HK_AGE:   idx_rs = ent_reg.ab;
            whlt_pkg::HK_GAP:   idx_rs = ent_reg.gb;
            whlt_pkg::HK_DENS:  idx_rs = 6'(ent_reg.db);
            default:            idx_rs = {cg_reg, ca_reg};
        endcase
    end

    assign h_addr_rs = whlt_pkg::hist_addr(hcnt_reg, y_reg, idx_rs);

    // Memory read addresses.
    always_comb
    begin
        case (state_reg)
            whlt_pkg::ST_SW_RD:  g_raddr = sweep_idx_reg[11:0];
            whlt_pkg::ST_RS_SEQ: g_raddr = ent_reg.grp;
            default:             g_raddr = cmd_reg.grp;
        endcase
        if (state_reg == whlt_pkg::ST_RS_HRD)
        begin
            h_raddr = h_addr_rs;
        end
        else
        begin
            h_raddr = whlt_pkg::hist_addr(cmd_reg.hk, cmd_reg.hlab, cmd_reg.hidx);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            whlt_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == '1) state_next = whlt_pkg::ST_IDLE;
            end
            whlt_pkg::ST_IDLE:
            begin
                if (q_valid) state_next = whlt_pkg::ST_DECODE;
            end
            whlt_pkg::ST_DECODE:
            begin
                case (cmd_reg.mode)
                    whlt_pkg::MODE_WRITE:
                    begin
                        if (!cmd_reg.in_range) state_next = whlt_pkg::ST_EMIT;
                        else if (ldt_reg != '0 && due) state_next = whlt_pkg::ST_SW_RD;
                        else state_next = whlt_pkg::ST_GRD;
                    end
                    whlt_pkg::MODE_SAMPLE:
                    begin
                        if (!cmd_reg.in_range || full) state_next = whlt_pkg::ST_EMIT;
                        else state_next = whlt_pkg::ST_GRD;
                    end
                    whlt_pkg::MODE_RESOLVE: state_next = whlt_pkg::ST_RS_CHK;
                    default:
                    begin
                        if (rd_direct) state_next = whlt_pkg::ST_EMIT;
                        else state_next = whlt_pkg::ST_HRD;
                    end
                endcase
            end
            whlt_pkg::ST_SW_RD: state_next = whlt_pkg::ST_SW_WB;
            whlt_pkg::ST_SW_WB:
            begin
                if (13'(sweep_idx_reg + 13'd1) == live) state_next = whlt_pkg::ST_GRD;
                else state_next = whlt_pkg::ST_SW_RD;
            end
            whlt_pkg::ST_GRD: state_next = whlt_pkg::ST_G1;
            whlt_pkg::ST_G1:
            begin
                if (cmd_reg.mode == whlt_pkg::MODE_WRITE) state_next = whlt_pkg::ST_WR_WB;
                else state_next = whlt_pkg::ST_SMP_WB;
            end
            whlt_pkg::ST_WR_WB:  state_next = whlt_pkg::ST_EMIT;
            whlt_pkg::ST_SMP_WB: state_next = whlt_pkg::ST_EMIT;
            whlt_pkg::ST_EMIT:
            begin
                if (out_free) state_next = whlt_pkg::ST_IDLE;
            end
            whlt_pkg::ST_HRD: state_next = whlt_pkg::ST_H1;
            whlt_pkg::ST_H1:  state_next = whlt_pkg::ST_EMIT;
            whlt_pkg::ST_RS_CHK:
            begin
                if (head_reg == tail_reg || nres_reg == 7'(whlt_pkg::BURST_MAX))
                    state_next = whlt_pkg::ST_RS_FIN;
                else
                    state_next = whlt_pkg::ST_RS_RD;
            end
            whlt_pkg::ST_RS_RD:
            begin
                if (late) state_next = whlt_pkg::ST_RS_FIN;
                else state_next = whlt_pkg::ST_RS_FLUSH;
            end
            whlt_pkg::ST_RS_FLUSH:
            begin
                if (!pend_reg || out_free) state_next = whlt_pkg::ST_RS_SEQ;
            end
            whlt_pkg::ST_RS_SEQ: state_next = whlt_pkg::ST_RS_LBL;
            whlt_pkg::ST_RS_LBL: state_next = whlt_pkg::ST_RS_DIV;
            whlt_pkg::ST_RS_DIV:
            begin
                if (div_done) state_next = whlt_pkg::ST_RS_HRD;
            end
            whlt_pkg::ST_RS_HRD: state_next = whlt_pkg::ST_RS_HWB;
            whlt_pkg::ST_RS_HWB:
            begin
                if (hcnt_reg == whlt_pkg::HK_PAIR) state_next = whlt_pkg::ST_RS_DONE;
                else state_next = whlt_pkg::ST_RS_HRD;
            end
            whlt_pkg::ST_RS_DONE: state_next = whlt_pkg::ST_RS_CHK;
            whlt_pkg::ST_RS_FIN:
            begin
                if (out_free) state_next = whlt_pkg::ST_IDLE;
            end
            default: state_next = whlt_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory writes and result pushes.
    always_comb
    begin
        whlt_pkg::grp_t gw;

        cmd_next       = cmd_reg;
        g_next         = g_reg;
        ent_next       = ent_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_v_next     = out_v_reg && !res_ch.ready;
        clr_idx_next   = clr_idx_reg;
        sweep_idx_next = sweep_idx_reg;
        ldt_next       = ldt_reg;
        drop_next      = drop_reg;
        diff_next      = diff_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        nres_next      = nres_reg;
        pend_next      = pend_reg;
        y_next         = y_reg;
        rg_next        = rg_reg;
        ra_next        = ra_reg;
        cg_next        = cg_reg;
        ca_next        = ca_reg;
        hcnt_next      = hcnt_reg;
        q_pop          = 1'b0;
        g_we           = 1'b0;
        g_waddr        = cmd_reg.grp;
        g_wdata        = g_reg;
        r_we           = 1'b0;
        r_wdata        = ent_reg;
        h_we           = 1'b0;
        h_waddr        = h_addr_rs;
        h_wdata        = 64'(h_rdata + 64'd1);
        gw             = g_reg;

        case (state_reg)
            // Clearing pass over the group and histogram memories.
            whlt_pkg::ST_CLEAR:
            begin
                g_we         = 1'b1;
                g_waddr      = clr_idx_reg;
                g_wdata      = '0;
                h_we         = clr_idx_reg < 12'(whlt_pkg::HIST_DEPTH);
                h_waddr      = clr_idx_reg[whlt_pkg::HIST_AW-1:0];
                h_wdata      = '0;
                clr_idx_next = 12'(clr_idx_reg + 12'd1);
            end
            whlt_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                end
            end
            whlt_pkg::ST_DECODE:
            begin
                res_next      = '0;
                res_next.kind = whlt_pkg::RK_DONE;
                res_next.last = 1'b1;
                case (cmd_reg.mode)
                    whlt_pkg::MODE_WRITE:
                    begin
                        if (cmd_reg.in_range)
                        begin
                            if (ldt_reg == '0 || due) ldt_next = cmd_reg.now;
                            sweep_idx_next = '0;
                        end
                    end
                    whlt_pkg::MODE_SAMPLE:
                    begin
                        if (cmd_reg.in_range && full)
                        begin
                            drop_next     = 64'(drop_reg + 64'd1);
                            res_next.kind = whlt_pkg::RK_DROP;
                        end
                    end
                    whlt_pkg::MODE_RESOLVE:
                    begin
                        nres_next = '0;
                        pend_next = 1'b0;
                    end
                    default:
                    begin
                        res_next.kind = whlt_pkg::RK_COUNTER;
                        if (cmd_reg.hk == whlt_pkg::HK_DROPPED)
                            res_next.value = drop_reg;
                        else if (cmd_reg.hk == whlt_pkg::HK_PENDING)
                            res_next.value = 64'(6'(tail_reg - head_reg));
                    end
                endcase
            end
            // Decay sweep: halve each live group's frequency.
            whlt_pkg::ST_SW_WB:
            begin
                gw             = g_rdata;
                gw.freq        = g_rdata.freq >> 1;
                g_we           = 1'b1;
                g_waddr        = sweep_idx_reg[11:0];
                g_wdata        = gw;
                sweep_idx_next = 13'(sweep_idx_reg + 13'd1);
            end
            whlt_pkg::ST_G1:
            begin
                g_next    = g_rdata;
                diff_next = cmd_reg.now - g_rdata.last_inval;
            end
            // Host write update of one group.
            whlt_pkg::ST_WR_WB:
            begin
                if (!cmd_reg.ow)
                begin
                    if (g_reg.mapped < 7'(whlt_pkg::PAGES_PER_GROUP))
                        gw.mapped = 7'(g_reg.mapped + 7'd1);
                end
                else
                begin
                    if (g_reg.last_inval != '0 && cmd_reg.now > g_reg.last_inval)
                    begin
                        if (g_reg.gap_avg == '0)
                            gw.gap_avg = diff_reg;
                        else
                            gw.gap_avg = g_reg.gap_avg + (diff_reg >> 3) - (g_reg.gap_avg >> 3);
                    end
                    gw.last_inval = cmd_reg.now;
                    gw.seq        = 32'(g_reg.seq + 32'd1);
                    if (g_reg.freq < whlt_pkg::FREQ_TOP) gw.freq = 16'(g_reg.freq + 16'd1);
                end
                g_we    = 1'b1;
                g_wdata = gw;
            end
            // Snapshot of a group into the ring.
            whlt_pkg::ST_SMP_WB:
            begin
                r_we         = 1'b1;
                r_wdata.t0   = cmd_reg.now;
                r_wdata.grp  = cmd_reg.grp;
                r_wdata.seq0 = g_reg.seq;
                r_wdata.fb   = whlt_pkg::bit_len16(g_reg.freq);
                r_wdata.ab   = whlt_pkg::log_bin((g_reg.last_inval != '0) ? diff_reg : '1);
                r_wdata.gb   = whlt_pkg::log_bin((g_reg.gap_avg != '0) ? g_reg.gap_avg : '1);
                r_wdata.db   = whlt_pkg::dens_bin(g_reg.mapped);
                tail_next    = 6'(tail_reg + 6'd1);
            end
            whlt_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_v_next = 1'b1;
                    out_next   = res_reg;
                end
            end
            whlt_pkg::ST_H1:
            begin
                res_next.value = h_rdata;
            end
            whlt_pkg::ST_RS_RD:
            begin
                ent_next = r_rdata;
            end
            // The previous resolved sample is not the last one.
            whlt_pkg::ST_RS_FLUSH:
            begin
                if (pend_reg && out_free)
                begin
                    out_v_next    = 1'b1;
                    out_next      = res_reg;
                    out_next.last = 1'b0;
                    pend_next     = 1'b0;
                end
            end
            whlt_pkg::ST_RS_LBL:
            begin
                y_next    = g_rdata.seq != ent_reg.seq0;
                rg_next   = (ent_reg.gb >= cfg.coarse_base) ? 6'(ent_reg.gb - cfg.coarse_base) : '0;
                ra_next   = (ent_reg.ab >= cfg.coarse_base) ? 6'(ent_reg.ab - cfg.coarse_base) : '0;
                cg_next   = '0;
                ca_next   = '0;
                hcnt_next = whlt_pkg::HK_LABEL;
            end
            // Coarse bins by repeated subtraction, capped at bin seven.
            whlt_pkg::ST_RS_DIV:
            begin
                if (!stop_g)
                begin
                    rg_next = 6'(rg_reg - step_eff);
                    cg_next = 3'(cg_reg + 3'd1);
                end
                if (!stop_a)
                begin
                    ra_next = 6'(ra_reg - step_eff);
                    ca_next = 3'(ca_reg + 3'd1);
                end
            end
            whlt_pkg::ST_RS_HWB:
            begin
                h_we      = 1'b1;
                hcnt_next = 3'(hcnt_reg + 3'd1);
            end
            whlt_pkg::ST_RS_DONE:
            begin
                res_next.kind  = whlt_pkg::RK_RESOLVED;
                res_next.label = y_reg;
                res_next.fb    = ent_reg.fb;
                res_next.ab    = ent_reg.ab;
                res_next.gb    = ent_reg.gb;
                res_next.db    = ent_reg.db;
                res_next.gc    = cg_reg;
                res_next.ac    = ca_reg;
                res_next.grp   = ent_reg.grp;
                res_next.value = '0;
                res_next.last  = 1'b0;
                pend_next      = 1'b1;
                head_next      = 6'(head_reg + 6'd1);
                nres_next      = 7'(nres_reg + 7'd1);
            end
            whlt_pkg::ST_RS_FIN:
            begin
                if (out_free)
                begin
                    out_v_next = 1'b1;
                    if (pend_reg)
                    begin
                        out_next = res_reg;
                    end
                    else
                    begin
                        out_next      = '0;
                        out_next.kind = whlt_pkg::RK_DONE;
                    end
                    out_next.last = 1'b1;
                    pend_next     = 1'b0;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= whlt_pkg::ST_CLEAR;
            out_v_reg     <= 1'b0;
            clr_idx_reg   <= '0;
            sweep_idx_reg <= '0;
            ldt_reg       <= '0;
            drop_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            nres_reg      <= '0;
            pend_reg      <= 1'b0;
            hcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_v_reg     <= out_v_next;
            clr_idx_reg   <= clr_idx_next;
            sweep_idx_reg <= sweep_idx_next;
            ldt_reg       <= ldt_next;
            drop_reg      <= drop_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            nres_reg      <= nres_next;
            pend_reg      <= pend_next;
            hcnt_reg      <= hcnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        g_reg    <= g_next;
        ent_reg  <= ent_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        diff_reg <= diff_next;
        y_reg    <= y_next;
        rg_reg   <= rg_next;
        ra_reg   <= ra_next;
        cg_reg   <= cg_next;
        ca_reg   <= ca_next;
    end

    // Result channel.
    assign res_ch.valid         = out_v_reg;
    assign res_ch.result_kind   = out_reg.kind;
    assign res_ch.label         = out_reg.label;
    assign res_ch.freq_bin      = out_reg.fb;
    assign res_ch.age_bin       = out_reg.ab;
    assign res_ch.gap_bin       = out_reg.gb;
    assign res_ch.dens_bin      = out_reg.db;
    assign res_ch.gap_coarse    = out_reg.gc;
    assign res_ch.age_coarse    = out_reg.ac;
    assign res_ch.group_index   = out_reg.grp;
    assign res_ch.counter_value = out_reg.value;
    assign res_ch.last          = out_reg.last;

endmodule

@@ design/whlt_checker.sv @@
// Result channel checker for the write hotness label tracker and its bind.
`include "write_hotness_label_tracker_defines.svh"

module whlt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic [1:0]  kind,
    input logic        last,
    input logic        label,
    input logic [11:0] group_index,
    input logic [63:0] counter_value
);

    // Only resolved samples come in bursts; every other result ends its request.
    `WHLT_ASSERT_IMPLY(a_single_last, clk, rst_n, valid && kind != whlt_pkg::RK_RESOLVED, last)

    // Counter values appear only on counter results.
    `WHLT_ASSERT_IMPLY(a_value_zero, clk, rst_n, valid && kind != whlt_pkg::RK_COUNTER, counter_value == '0)

    // Label and group fields appear only on resolved samples.
    `WHLT_ASSERT_IMPLY(a_sample_zero, clk, rst_n, valid && kind != whlt_pkg::RK_RESOLVED, label == 1'b0 && group_index == '0)

    // A stalled transfer stays offered.
    `WHLT_ASSERT_NEXT(a_hold_valid, clk, rst_n, valid && !ready, valid)

endmodule

bind write_hotness_label_tracker whlt_checker u_whlt_checker (
    .clk(clk), .rst_n(rst_n), .valid(res_ch.valid), .ready(res_ch.ready),
    .kind(res_ch.result_kind), .last(res_ch.last), .label(res_ch.label),
    .group_index(res_ch.group_index), .counter_value(res_ch.counter_value)
);

@@ bench/hotness_monitor.sv @@
// Checker that predicts every result of the write hotness label tracker and compares transfers.
module hotness_monitor
    import whlt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    whlt_in_if                   in_ch,
    whlt_res_if                  res_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   errors,
    output int                   outstanding
);

    // One snapshot held in the sample ring.
    typedef struct {
        logic [63:0] t0;
        logic [63:0] age;
        logic [63:0] gap;
        logic [11:0] grp;
        logic [31:0] seq0;
        logic [15:0] freq;
        int unsigned dens;
    } snapshot_t;

    // Configuration copy.
    logic [12:0] n_groups;
    logic [39:0] horizon;
    logic [39:0] period;
    logic [5:0]  cbase;
    logic [5:0]  cstep;

    // Per-group statistics.
    logic [15:0] freq_tab [MAX_GROUPS];
    logic [6:0]  mapped_tab [MAX_GROUPS];
    logic [63:0] gap_tab [MAX_GROUPS];
    logic [63:0] inval_tab [MAX_GROUPS];
    logic [31:0] seq_tab [MAX_GROUPS];

    // Sample ring and counters.
    snapshot_t   ring [RING_DEPTH];
    logic [5:0]  head;
    logic [5:0]  tail;
    logic [63:0] drops;
    logic [63:0] decay_mark;
    logic [63:0] label_cnt [2];
    logic [63:0] freq_cnt [2*FREQ_BINS];
    logic [63:0] age_cnt [2*LOG_BINS];
    logic [63:0] gap_cnt [2*LOG_BINS];
    logic [63:0] dens_cnt [2*DENS_BINS];
    logic [63:0] pair_cnt [128];

    res_t expected_results [$];

    // Floor log2 bucket; zero goes to bin 0 and all ones to the top bin.
    function automatic logic [5:0] log2_bin(input logic [63:0] v);
        int msb;
        msb = 0;
        if (v == '0)
            return 6'd0;
        if (&v)
            return 6'(LOG_BINS - 1);
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
                msb = i;
        end
        return (msb >= LOG_BINS) ? 6'(LOG_BINS - 1) : 6'(msb);
    endfunction

    // Bit length of a frequency, clamped to the last bin.
    function automatic logic [4:0] freq_bucket(input logic [15:0] f);
        int n;
        n = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (f[i])
                n = i + 1;
        end
        return (n >= FREQ_BINS) ? 5'(FREQ_BINS - 1) : 5'(n);
    endfunction

    // Coarse bin of a log2 bucket; a zero step counts as one.
    function automatic logic [2:0] coarse_of(input logic [5:0] lb);
        int step;
        int c;
        step = (cstep == 0) ? 1 : int'(cstep);
        if (lb < cbase)
            return 3'd0;
        c = (int'(lb) - int'(cbase)) / step;
        return (c > 7) ? 3'd7 : 3'(c);
    endfunction

    function automatic res_t blank_result(input logic [1:0] kind);
        res_t r;
        r = '0;
        r.kind = kind;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic reset_model();
        n_groups = 13'd4096;
        horizon = 40'd100000000;
        period = 40'd1000000000;
        cbase = 6'd18;
        cstep = 6'd3;
        for (int i = 0; i < MAX_GROUPS; i++)
        begin
            freq_tab[i] = '0;
            mapped_tab[i] = '0;
            gap_tab[i] = '0;
            inval_tab[i] = '0;
            seq_tab[i] = '0;
        end
        head = '0;
        tail = '0;
        drops = '0;
        decay_mark = '0;
        label_cnt[0] = '0;
        label_cnt[1] = '0;
        foreach (freq_cnt[i]) freq_cnt[i] = '0;
        foreach (age_cnt[i]) age_cnt[i] = '0;
        foreach (gap_cnt[i]) gap_cnt[i] = '0;
        foreach (dens_cnt[i]) dens_cnt[i] = '0;
        foreach (pair_cnt[i]) pair_cnt[i] = '0;
        expected_results.delete();
        errors = 0;
    endtask

    // Update the statistics for one accepted request and queue the results it causes.
    task automatic predict_request();
        logic [63:0] now;
        logic [63:0] gapv;
        logic [63:0] v;
        logic        in_range;
        logic [11:0] g;
        logic [5:0]  nxt;
        logic [5:0]  idx;
        logic        yb;
        int          live;
        int          n;
        int          y;
        snapshot_t   s;
        res_t        r;
        now = in_ch.now_ns;
        live = (n_groups > 13'(MAX_GROUPS)) ? MAX_GROUPS : int'(n_groups);
        in_range = int'(in_ch.lpn >> PG_SHIFT) < live;
        g = in_range ? in_ch.lpn[17:6] : '0;
        n = 0;
        case (in_ch.mode)
            MODE_WRITE:
            begin
                if (in_range)
                begin
                    // Decay bookkeeping comes first: once a period has passed it halves every live group.
                    if (decay_mark == '0)
                        decay_mark = now;
                    else if (now - decay_mark >= 64'(period))
                    begin
                        for (int i = 0; i < live; i++)
                            freq_tab[i] = freq_tab[i] >> 1;
                        decay_mark = now;
                    end
                    if (!in_ch.overwrite)
                    begin
                        if (mapped_tab[g] < PAGES_PER_GROUP)
                            mapped_tab[g]++;
                    end
                    else
                    begin
                        if (inval_tab[g] != '0 && now > inval_tab[g])
                        begin
                            gapv = now - inval_tab[g];
                            if (gap_tab[g] == '0)
                                gap_tab[g] = gapv;
                            else
                                gap_tab[g] = gap_tab[g] + (gapv >> 3) - (gap_tab[g] >> 3);
                        end
                        inval_tab[g] = now;
                        seq_tab[g]++;
                        if (freq_tab[g] != FREQ_TOP)
                            freq_tab[g]++;
                    end
                end
                expected_results.push_back(blank_result(RK_DONE));
            end
            MODE_SAMPLE:
            begin
                nxt = tail + 6'd1;
                if (!in_range)
                    expected_results.push_back(blank_result(RK_DONE));
                else if (nxt == head)
                begin
                    drops++;
                    expected_results.push_back(blank_result(RK_DROP));
                end
                else
                begin
                    s.t0 = now;
                    s.grp = g;
                    s.seq0 = seq_tab[g];
                    s.freq = freq_tab[g];
                    s.age = (inval_tab[g] != '0) ? now - inval_tab[g] : '1;
                    s.gap = (gap_tab[g] != '0) ? gap_tab[g] : '1;
                    s.dens = int'(mapped_tab[g]) * 100 / PAGES_PER_GROUP;
                    ring[tail] = s;
                    tail = nxt;
                    expected_results.push_back(blank_result(RK_DONE));
                end
            end
            MODE_RESOLVE:
            begin
                // Label the oldest samples whose horizon has passed, up to one burst.
                while (head != tail && n < BURST_MAX)
                begin
                    s = ring[head];
                    if (s.t0 + 64'(horizon) > now)
                        break;
                    r = blank_result(RK_RESOLVED);
                    y = (seq_tab[s.grp] != s.seq0) ? 1 : 0;
                    r.label = y[0];
                    r.fb = freq_bucket(s.freq);
                    r.ab = log2_bin(s.age);
                    r.gb = log2_bin(s.gap);
                    r.db = (s.dens / 10 >= DENS_BINS) ? 4'(DENS_BINS - 1) : 4'(s.dens / 10);
                    r.gc = coarse_of(r.gb);
                    r.ac = coarse_of(r.ab);
                    r.grp = s.grp;
                    label_cnt[y]++;
                    freq_cnt[y * FREQ_BINS + int'(r.fb)]++;
                    age_cnt[y * LOG_BINS + int'(r.ab)]++;
                    gap_cnt[y * LOG_BINS + int'(r.gb)]++;
                    dens_cnt[y * DENS_BINS + int'(r.db)]++;
                    pair_cnt[y * 64 + int'(r.gc) * 8 + int'(r.ac)]++;
                    expected_results.push_back(r);
                    n++;
                    head = head + 6'd1;
                end
                if (n == 0)
                    expected_results.push_back(blank_result(RK_DONE));
            end
            default:
            begin
                idx = in_ch.hist_index;
                yb = in_ch.hist_label;
                case (in_ch.hist_kind)
                    HK_LABEL:   v = label_cnt[yb];
                    HK_FREQ:    v = (idx < FREQ_BINS) ? freq_cnt[int'(yb) * FREQ_BINS + idx] : '0;
                    HK_AGE:     v = (idx < LOG_BINS) ? age_cnt[int'(yb) * LOG_BINS + idx] : '0;
                    HK_GAP:     v = (idx < LOG_BINS) ? gap_cnt[int'(yb) * LOG_BINS + idx] : '0;
                    HK_DENS:    v = (idx < DENS_BINS) ? dens_cnt[int'(yb) * DENS_BINS + idx] : '0;
                    HK_PAIR:    v = pair_cnt[int'(yb) * 64 + idx];
                    HK_DROPPED: v = drops;
                    default:    v = 64'(6'(tail - head));
                endcase
                r = blank_result(RK_COUNTER);
                r.value = v;
                expected_results.push_back(r);
            end
        endcase
        expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Compare one result transfer with the oldest expectation.
    task automatic check_result();
        res_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result transfer with nothing expected");
            return;
        end
        want = expected_results.pop_front();
        compare_field("result_kind", res_ch.result_kind, want.kind);
        compare_field("label", res_ch.label, want.label);
        compare_field("freq_bin", res_ch.freq_bin, want.fb);
        compare_field("age_bin", res_ch.age_bin, want.ab);
        compare_field("gap_bin", res_ch.gap_bin, want.gb);
        compare_field("dens_bin", res_ch.dens_bin, want.db);
        compare_field("gap_coarse", res_ch.gap_coarse, want.gc);
        compare_field("age_coarse", res_ch.age_coarse, want.ac);
        compare_field("group_index", res_ch.group_index, want.grp);
        compare_field("counter_value", res_ch.counter_value, want.value);
        compare_field("last", res_ch.last, want.last);
    endtask

    // Register writes, request transfers and result transfers, in that order per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reset_model();
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GROUP_COUNT: n_groups = cfg_data[12:0];
                    CFG_HORIZON:     horizon = cfg_data;
                    CFG_PERIOD:      period = cfg_data;
                    CFG_COARSE_BASE: cbase = cfg_data[5:0];
                    CFG_COARSE_STEP: cstep = cfg_data[5:0];
                    default:         ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                predict_request();
            if (res_ch.valid && res_ch.ready)
                check_result();
        end
        outstanding = expected_results.size();
    end

endmodule

@@ bench/testbench.sv @@
// Top of the testbench: clock, reset, request and register stimulus, result stalls, verdict.
module testbench;
    import whlt_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   errors;
    int                   outstanding;
    int                   sent_count;
    int                   cycles = 0;
    int                   live;
    logic [63:0]          clock_ns;

    whlt_in_if  req_ch ();
    whlt_res_if res_ch ();

    write_hotness_label_tracker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (req_ch),
        .res_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hotness_monitor u_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (req_ch),
        .res_ch      (res_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit, far above the slowest correct run including the clearing pass.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 10000000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one request and wait for its transfer.
    task automatic send(input logic [1:0] mode, input logic [31:0] lpn, input logic [63:0] now,
                        input logic ow, input logic [2:0] kind, input logic [5:0] idx,
                        input logic lab);
        int gap;
        gap = ((sent_count / 30) % 3 == 2) ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode <= mode;
        req_ch.lpn <= lpn;
        req_ch.now_ns <= now;
        req_ch.overwrite <= ow;
        req_ch.hist_kind <= kind;
        req_ch.hist_index <= idx;
        req_ch.hist_label <= lab;
        do @(posedge clk); while (!req_ch.ready);
        sent_count++;
    endtask

    // Random request: mostly in-range groups with advancing time, some noise.
    task automatic rand_item(input int w_sample, input int w_resolve, input int w_read,
                             input bit noisy, input int adv_max);
        int          pick;
        logic [1:0]  mode;
        logic [31:0] lpn;
        logic [63:0] now;
        pick = $urandom_range(0, 99);
        if (pick < w_sample)
            mode = MODE_SAMPLE;
        else if (pick < w_sample + w_resolve)
            mode = MODE_RESOLVE;
        else if (pick < w_sample + w_resolve + w_read)
            mode = MODE_READ;
        else
            mode = MODE_WRITE;
        if (live > 0 && $urandom_range(0, 9) != 0)
            lpn = $urandom_range(0, live * PAGES_PER_GROUP - 1);
        else
            lpn = $urandom;
        if (noisy && $urandom_range(0, 24) == 0)
            now = {$urandom, $urandom};
        else
        begin
            clock_ns = clock_ns + 64'($urandom_range(0, adv_max));
            now = clock_ns;
        end
        send(mode, lpn, now, $urandom_range(0, 3) != 0, 3'($urandom_range(0, 7)),
             6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Let the block drain, then load a new register setting.
    task automatic configure(input logic [12:0] gc, input logic [39:0] hz,
                             input logic [39:0] per, input logic [5:0] base,
                             input logic [5:0] step);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        write_reg(CFG_GROUP_COUNT, 40'(gc));
        write_reg(CFG_HORIZON, hz);
        write_reg(CFG_PERIOD, per);
        write_reg(CFG_COARSE_BASE, 40'(base));
        write_reg(CFG_COARSE_STEP, 40'(step));
        cfg_we <= 1'b0;
        live = (gc > 13'(MAX_GROUPS)) ? MAX_GROUPS : int'(gc);
    endtask

    // Result side: random stalls, stretches without stalls, and one long hold-off.
    initial
    begin
        bit held;
        int stall;
        int taken;
        held = 1'b0;
        taken = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            if (!held && sent_count >= 90)
            begin
                res_ch.ready <= 1'b0;
                repeat (700) @(posedge clk);
                held = 1'b1;
            end
            stall = ((taken / 40) % 3 == 1) ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            taken++;
        end
    end

    // Request stimulus and verdict.
    initial
    begin
        rst_n = 1'b0;
        sent_count = 0;
        live = MAX_GROUPS;
        clock_ns = 64'd100;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_WRITE;
        req_ch.lpn = '0;
        req_ch.now_ns = '0;
        req_ch.overwrite = 1'b0;
        req_ch.hist_kind = HK_LABEL;
        req_ch.hist_index = '0;
        req_ch.hist_label = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: decay start, overwrite gaps, out-of-range groups, early and due
        // resolves, groups without history, every counter kind, decay with time wrap.
        configure(13'd4, 40'd1000, 40'd50000, 6'd0, 6'd1);
        send(MODE_READ, 32'd0, 64'd0, 1'b0, HK_PENDING, 6'd0, 1'b0);
        send(MODE_WRITE, 32'd0, 64'd100, 1'b0, HK_LABEL, 6'd0, 1'b0);
        send(MODE_WRITE, 32'd0, 64'd200, 1'b1, HK_LABEL, 6'd0, 1'b0);
        send(MODE_WRITE, 32'd0, 64'd700, 1'b1, HK_LABEL, 6'd0, 1'b0);
        send(MODE_WRITE, 32'd63, 64'd900, 1'b1, HK_LABEL, 6'd0, 1'b0);
        send(MODE_WRITE, 32'd256, 64'd1000, 1'b1, HK_LABEL, 6'd0, 1'b0);
        send(MODE_WRITE, 32'hFFFF_FFFF, 64'd1000, 1'b1, HK_LABEL, 6'd0, 1'b0);
        send(MODE_SAMPLE, 32'd0, 64'd1000, 1'b0, HK_LABEL, 6'd0, 1'b0);
        send(MODE_SAMPLE, 32'd255, 64'd1100, 1'b0, HK_LABEL, 6'd0, 1'b0);
        send(MODE_SAMPLE, 32'hFFFF_FFFF, 64'd1100, 1'b0, HK_LABEL, 6'd0, 1'b0);
        send(MODE_RESOLVE, 32'd0, 64'd1500, 1'b0, HK_LABEL, 6'd0, 1'b0);
        send(MODE_WRITE, 32'd0, 64'd1800, 1'b1, HK_LABEL, 6'd0, 1'b0);
        send(MODE_RESOLVE, 32'd0, 64'd2100, 1'b0, HK_LABEL, 6'd0, 1'b0);
        send(MODE_READ, 32'd0, 64'd0, 1'b0, HK_LABEL, 6'd0, 1'b1);
        send(MODE_READ, 32'd0, 64'd0, 1'b0, HK_FREQ, 6'd1, 1'b1);
        send(MODE_READ, 32'd0, 64'd0, 1'b0, HK_AGE, 6'd63, 1'b0);
        send(MODE_READ, 32'd0, 64'd0, 1'b0, HK_GAP, 6'd39, 1'b0);
        send(MODE_READ, 32'd0, 64'd0, 1'b0, HK_DENS, 6'd11, 1'b1);
        send(MODE_READ, 32'd0, 64'd0, 1'b0, HK_PAIR, 6'd63, 1'b1);
        send(MODE_READ, 32'd0, 64'd0, 1'b0, HK_DROPPED, 6'd0, 1'b0);
        send(MODE_READ, 32'd0, 64'd0, 1'b0, HK_PENDING, 6'd0, 1'b0);
        send(MODE_WRITE, 32'd5, 64'd60000, 1'b1, HK_LABEL, 6'd0, 1'b0);
        send(MODE_WRITE, 32'd128, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, HK_LABEL, 6'd0, 1'b0);
        clock_ns = 64'd61000;

        // Mixed traffic over a few groups; the long result hold-off falls here.
        configure(13'd16, 40'd4000, 40'd30000, 6'd8, 6'd2);
        repeat (150) rand_item(20, 10, 10, 1'b1, 600);

        // One group, decay on every write, zero coarse step: the ring fills and drops.
        configure(13'd1, 40'd200, 40'd1, 6'd39, 6'd0);
        repeat (90) rand_item(60, 3, 10, 1'b1, 20);

        // Group count above the table depth and the widest horizon and period.
        configure(13'd8191, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 6'd0, 6'd39);
        repeat (60) rand_item(15, 10, 10, 1'b0, 5000);
        clock_ns = clock_ns + 64'h200_0000_0000;
        send(MODE_WRITE, 32'd0, clock_ns, 1'b1, HK_LABEL, 6'd0, 1'b0);

        // No live groups: everything but resolves and reads is ignored; the ring drains.
        configure(13'd0, 40'd1, 40'd1000, 6'd20, 6'd5);
        repeat (15) rand_item(20, 30, 20, 1'b1, 100);

        // Sample times near the top of the time range, so the horizon sum wraps.
        configure(13'd32, 40'hFF_FFFF_FFFF, 40'd5000, 6'd25, 6'd1);
        clock_ns = 64'hFFFF_FF00_0000_0000;
        repeat (120) rand_item(20, 12, 10, 1'b1, 4000);

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
